FILE: rtl/core/alft_pkg.sv
package alft_pkg;

    localparam int MAX_ARGS   = 32;
    localparam int MAX_COLUMN = 255;
    localparam int ARG_W      = $clog2(MAX_ARGS + 1);
    localparam int COL_W      = $clog2(MAX_COLUMN + 1);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [3:0] {
        PH_START, PH_LABEL, PH_SUFFIX, PH_OP_SEEK, PH_STAR_EQ, PH_OPCODE,
        PH_ARG_SEEK, PH_STRING, PH_CHAR1, PH_CHAR2, PH_PLAIN, PH_AFTER_LIT,
        PH_ARG_NEXT, PH_TRAIL, PH_COMMENT
    } t_phase;

    typedef enum logic [2:0] {
        CLS_SEP, CLS_LABEL, CLS_SUFFIX, CLS_OPCODE, CLS_ARG, CLS_COMMENT
    } t_class;

    typedef struct packed {
        t_phase phase;
        t_class cls;
        logic   start;
        logic   inc;
    } t_step;

    typedef struct packed {
        t_phase           phase;
        t_class           cls;
        logic             start;
        logic             err;
        logic [ARG_W-1:0] arg_count;
    } t_tag;

    typedef struct packed {
        logic [7:0] char_out;
        t_class     cls;
        logic [4:0] arg_index;
        logic       start;
        logic [7:0] column;
        logic       err;
    } t_result;

    function automatic logic is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_ident_start(logic [7:0] c);
        return is_alpha(c) || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic is_ident(logic [7:0] c);
        return is_ident_start(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_AT;
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return c == CH_EQ || c == CH_STAR;
    endfunction

endpackage

FILE: rtl/core/alft_classify.sv
module alft_classify (
    input  alft_pkg::t_phase               i_phase,
    input  logic [7:0]                     i_char,
    input  logic                           i_has_next,
    input  logic [7:0]                     i_next,
    input  logic                           i_macro_mode,
    input  logic [alft_pkg::ARG_W-1:0]     i_arg_count,
    output alft_pkg::t_tag                 o_tag
);

    function automatic alft_pkg::t_step mk(alft_pkg::t_phase ph, alft_pkg::t_class cls,
                                           logic st, logic inc);
        alft_pkg::t_step s;
        s.phase = ph;
        s.cls   = cls;
        s.start = st;
        s.inc   = inc;
        return s;
    endfunction

    function automatic alft_pkg::t_step f_trail(logic [7:0] c);
        if (alft_pkg::is_blank(c)) return mk(alft_pkg::PH_TRAIL, alft_pkg::CLS_SEP, 1'b0, 1'b0);
        return mk(alft_pkg::PH_COMMENT, alft_pkg::CLS_COMMENT, 1'b1, 1'b0);
    endfunction

    function automatic alft_pkg::t_step f_terminate(logic [7:0] c, logic inc);
        if (c == alft_pkg::CH_COMMA)
            return mk(alft_pkg::PH_ARG_SEEK, alft_pkg::CLS_SEP, 1'b0, inc);
        if (c == alft_pkg::CH_SEMI || alft_pkg::is_blank(c))
            return mk(alft_pkg::PH_TRAIL, alft_pkg::CLS_SEP, 1'b0, inc);
        return mk(alft_pkg::PH_ARG_NEXT, alft_pkg::CLS_SEP, 1'b0, inc);
    endfunction

    function automatic alft_pkg::t_step f_arg_begin(logic [7:0] c, logic full);
        if (full) return f_trail(c);
        if (c == alft_pkg::CH_DQ)
            return mk(alft_pkg::PH_STRING, alft_pkg::CLS_ARG, 1'b1, 1'b1);
        if (c == alft_pkg::CH_SQ)
            return mk(alft_pkg::PH_CHAR1, alft_pkg::CLS_ARG, 1'b1, 1'b1);
        if (c == alft_pkg::CH_COMMA || c == alft_pkg::CH_SEMI || alft_pkg::is_blank(c))
            return f_terminate(c, 1'b1);
        return mk(alft_pkg::PH_PLAIN, alft_pkg::CLS_ARG, 1'b1, 1'b1);
    endfunction

    function automatic alft_pkg::t_step f_arg_seek(logic [7:0] c, logic full);
        if (alft_pkg::is_blank(c))
            return mk(alft_pkg::PH_ARG_SEEK, alft_pkg::CLS_SEP, 1'b0, 1'b0);
        if (c == alft_pkg::CH_SEMI)
            return mk(alft_pkg::PH_COMMENT, alft_pkg::CLS_COMMENT, 1'b1, 1'b0);
        return f_arg_begin(c, full);
    endfunction

    function automatic alft_pkg::t_step f_op_seek(logic [7:0] c, logic star_eq, logic full);
        if (alft_pkg::is_blank(c))
            return mk(alft_pkg::PH_OP_SEEK, alft_pkg::CLS_SEP, 1'b0, 1'b0);
        if (c == alft_pkg::CH_SEMI)
            return mk(alft_pkg::PH_COMMENT, alft_pkg::CLS_COMMENT, 1'b1, 1'b0);
        if (c == alft_pkg::CH_STAR && star_eq)
            return mk(alft_pkg::PH_STAR_EQ, alft_pkg::CLS_OPCODE, 1'b1, 1'b0);
        if (c == alft_pkg::CH_EQ)
            return mk(alft_pkg::PH_ARG_SEEK, alft_pkg::CLS_OPCODE, 1'b1, 1'b0);
        if (alft_pkg::is_ident_start(c))
            return mk(alft_pkg::PH_OPCODE, alft_pkg::CLS_OPCODE, 1'b1, 1'b0);
        return f_arg_begin(c, full);
    endfunction

    logic            w_full;
    logic            w_star_eq;
    logic            w_bsl;
    logic            w_lab;
    logic            w_err;
    alft_pkg::t_step w_step;

    assign w_full    = i_arg_count >= alft_pkg::ARG_W'(alft_pkg::MAX_ARGS);
    assign w_star_eq = i_has_next && i_next == alft_pkg::CH_EQ;
    assign w_bsl     = i_macro_mode && i_char == alft_pkg::CH_BSL;
    assign w_lab     = alft_pkg::is_ident(i_char) || w_bsl;

    always_comb begin
        w_err  = 1'b0;
        w_step = mk(i_phase, alft_pkg::CLS_SEP, 1'b0, 1'b0);
        unique case (i_phase)
            alft_pkg::PH_START: begin
                if (i_char == alft_pkg::CH_SEMI || i_char == alft_pkg::CH_STAR
                        || i_char == alft_pkg::CH_HASH) begin
                    w_step = mk(alft_pkg::PH_COMMENT, alft_pkg::CLS_COMMENT, 1'b1, 1'b0);
                end else if (alft_pkg::is_blank(i_char)) begin
                    w_step = mk(alft_pkg::PH_OP_SEEK, alft_pkg::CLS_SEP, 1'b0, 1'b0);
                end else if (alft_pkg::is_ident_start(i_char) || w_bsl) begin
                    w_step = mk(alft_pkg::PH_LABEL, alft_pkg::CLS_LABEL, 1'b1, 1'b0);
                end else begin
                    w_err  = 1'b1;
                    w_step = f_op_seek(i_char, w_star_eq, w_full);
                end
            end
            alft_pkg::PH_LABEL: begin
                if (w_lab)
                    w_step = mk(alft_pkg::PH_LABEL, alft_pkg::CLS_LABEL, 1'b0, 1'b0);
                else if (alft_pkg::is_blank(i_char))
                    w_step = mk(alft_pkg::PH_OP_SEEK, alft_pkg::CLS_SEP, 1'b0, 1'b0);
                else if (alft_pkg::is_special(i_char))
                    w_step = f_op_seek(i_char, w_star_eq, w_full);
                else
                    w_step = mk(alft_pkg::PH_SUFFIX, alft_pkg::CLS_SUFFIX, 1'b1, 1'b0);
            end
            alft_pkg::PH_SUFFIX: begin
                if (alft_pkg::is_blank(i_char))
                    w_step = mk(alft_pkg::PH_OP_SEEK, alft_pkg::CLS_SEP, 1'b0, 1'b0);
                else if (alft_pkg::is_ident(i_char) || alft_pkg::is_special(i_char))
                    w_step = f_op_seek(i_char, w_star_eq, w_full);
                else
                    w_step = mk(alft_pkg::PH_SUFFIX, alft_pkg::CLS_SUFFIX, 1'b0, 1'b0);
            end
            alft_pkg::PH_OP_SEEK: w_step = f_op_seek(i_char, w_star_eq, w_full);
            alft_pkg::PH_STAR_EQ:
                w_step = mk(alft_pkg::PH_ARG_SEEK, alft_pkg::CLS_OPCODE, 1'b0, 1'b0);
            alft_pkg::PH_OPCODE: begin
                if (alft_pkg::is_ident(i_char))
                    w_step = mk(alft_pkg::PH_OPCODE, alft_pkg::CLS_OPCODE, 1'b0, 1'b0);
                else
                    w_step = f_arg_seek(i_char, w_full);
            end
            alft_pkg::PH_ARG_SEEK: w_step = f_arg_seek(i_char, w_full);
            alft_pkg::PH_STRING: begin
                if (i_char == alft_pkg::CH_DQ)
                    w_step = mk(alft_pkg::PH_AFTER_LIT, alft_pkg::CLS_ARG, 1'b0, 1'b0);
                else
                    w_step = mk(alft_pkg::PH_STRING, alft_pkg::CLS_ARG, 1'b0, 1'b0);
            end
            alft_pkg::PH_CHAR1:
                w_step = mk(alft_pkg::PH_CHAR2, alft_pkg::CLS_ARG, 1'b0, 1'b0);
            alft_pkg::PH_CHAR2: begin
                if (i_char == alft_pkg::CH_SQ)
                    w_step = mk(alft_pkg::PH_AFTER_LIT, alft_pkg::CLS_ARG, 1'b0, 1'b0);
                else
                    w_step = f_terminate(i_char, 1'b0);
            end
            alft_pkg::PH_PLAIN: begin
                if (i_char == alft_pkg::CH_COMMA || i_char == alft_pkg::CH_SEMI
                        || alft_pkg::is_blank(i_char))
                    w_step = f_terminate(i_char, 1'b0);
                else
                    w_step = mk(alft_pkg::PH_PLAIN, alft_pkg::CLS_ARG, 1'b0, 1'b0);
            end
            alft_pkg::PH_AFTER_LIT: w_step = f_terminate(i_char, 1'b0);
            alft_pkg::PH_ARG_NEXT:  w_step = f_arg_begin(i_char, w_full);
            alft_pkg::PH_TRAIL:     w_step = f_trail(i_char);
            default:
                w_step = mk(alft_pkg::PH_COMMENT, alft_pkg::CLS_COMMENT, 1'b0, 1'b0);
        endcase
    end

    always_comb begin
        o_tag.phase     = w_step.phase;
        o_tag.cls       = w_step.cls;
        o_tag.start     = w_step.start;
        o_tag.err       = w_err;
        o_tag.arg_count = i_arg_count + alft_pkg::ARG_W'(w_step.inc);
    end

endmodule

FILE: rtl/core/asm_line_field_tagger_unit.sv
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+--------------------------------------
// in        | sink      | i_in_valid / o_in_stall | i_char_in, i_line_end
// out       | source    | o_out_valid/i_out_stall | char_out, field_class, arg_index,
//           |           |                         | field_start, column, label_error
// cfg       | sink      | i_cfg_valid/o_cfg_ready | i_cfg_data (macro_mode)
//
// One item per cycle while the input is not stalled; a result is registered when the item
// after its character is accepted. The single-pass parse step between the held character
// register and the result register sets the rate. Reset returns the parser to the start of
// a line and empties both output stages. A stalled output holds one result plus one in the
// skid stage; the input stalls only while the skid stage is full. Config is always ready.
module asm_line_field_tagger_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic [2:0] o_field_class,
    output logic [4:0] o_arg_index,
    output logic       o_field_start,
    output logic [7:0] o_column,
    output logic       o_label_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    alft_pkg::t_phase                r_phase;
    logic [7:0]                      r_held_char;
    logic                            r_held_valid;
    logic [alft_pkg::ARG_W-1:0]      r_arg_count;
    logic [alft_pkg::COL_W-1:0]      r_column;
    logic                            r_macro_mode;
    logic                            r_out_valid;
    logic                            r_skid_valid;
    alft_pkg::t_result               r_out;
    alft_pkg::t_result               r_skid;

    alft_pkg::t_tag                  w_tag;
    alft_pkg::t_result               n_res;
    logic                            w_accept;
    logic                            w_produce;
    logic                            w_out_free;
    logic [alft_pkg::ARG_W-1:0]      w_idx;

    alft_classify u_classify (
        .i_phase      (r_phase),
        .i_char       (r_held_char),
        .i_has_next   (!i_line_end),
        .i_next       (i_char_in),
        .i_macro_mode (r_macro_mode),
        .i_arg_count  (r_arg_count),
        .o_tag        (w_tag)
    );

    assign o_in_stall  = r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_produce   = w_accept && r_held_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_idx       = w_tag.arg_count - alft_pkg::ARG_W'(1);

    always_comb begin
        n_res.char_out  = r_held_char;
        n_res.cls       = w_tag.cls;
        n_res.arg_index = (w_tag.cls == alft_pkg::CLS_ARG && w_tag.arg_count != '0)
                          ? 5'(w_idx) : 5'd0;
        n_res.start     = w_tag.start;
        n_res.column    = 8'(r_column);
        n_res.err       = w_tag.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= alft_pkg::PH_START;
            r_held_char  <= '0;
            r_held_valid <= 1'b0;
            r_arg_count  <= '0;
            r_column     <= '0;
            r_macro_mode <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_macro_mode <= i_cfg_data;
            end
            if (w_accept) begin
                if (i_line_end) begin
                    r_phase      <= alft_pkg::PH_START;
                    r_arg_count  <= '0;
                    r_column     <= '0;
                    r_held_valid <= 1'b0;
                    r_held_char  <= '0;
                end else begin
                    if (r_held_valid) begin
                        r_phase     <= w_tag.phase;
                        r_arg_count <= w_tag.arg_count;
                        if (r_column < alft_pkg::COL_W'(alft_pkg::MAX_COLUMN)) begin
                            r_column <= r_column + alft_pkg::COL_W'(1);
                        end
                    end
                    r_held_char  <= i_char_in;
                    r_held_valid <= 1'b1;
                end
            end
            if (w_out_free) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out        <= n_res;
                    r_out_valid  <= w_produce;
                end
            end else if (w_produce) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_out.char_out;
    assign o_field_class = r_out.cls;
    assign o_arg_index   = r_out.arg_index;
    assign o_field_start = r_out.start;
    assign o_column      = r_out.column;
    assign o_label_error = r_out.err;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item while output stage is empty");

    a_arg_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_arg_count <= alft_pkg::ARG_W'(alft_pkg::MAX_ARGS))
        else $error("argument count beyond limit");

    a_idx_only_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_class != alft_pkg::CLS_ARG) |-> o_arg_index == 5'd0)
        else $error("argument index outside an argument");

    a_sep_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_class == alft_pkg::CLS_SEP) |-> !o_field_start)
        else $error("separator flagged as field start");

    a_err_col0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_label_error) |-> o_column == 8'd0)
        else $error("label error away from the first column");

endmodule

FILE: tb/tb_asm_line_field_tagger_unit.sv
`timescale 1ns / 1ps

module tb_asm_line_field_tagger_unit;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_src_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_char_in = 8'h00;
    logic       i_line_end = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic [2:0] o_field_class;
    logic [4:0] o_arg_index;
    logic       o_field_start;
    logic [7:0] o_column;
    logic       o_label_error;
    logic       o_cfg_ready;

    t_src_item          line_q[$];
    alft_pkg::t_result  tags_due[$];
    t_src_item          cur;
    alft_pkg::t_result  want;

    bit         run_on = 1'b0;
    bit         in_fire = 1'b0;
    bit         hold_req = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         hold_left = 0;
    int         in_idle_pct = 0;
    int         out_idle_pct = 0;
    int         total_sent = 0;
    int         total_taken = 0;
    int         n_lines = 0;
    int         n_checked = 0;
    int         fails = 0;

    // parser mirror
    bit                macro_on = 1'b0;
    alft_pkg::t_phase  line_ph = alft_pkg::PH_START;
    logic [7:0]        held_ch = 8'h00;
    bit                held_ok = 1'b0;
    int                n_args = 0;
    int                col = 0;
    alft_pkg::t_class  tag_cls;
    logic              tag_st;
    logic              tag_err;

    asm_line_field_tagger_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_in    (i_char_in),
        .i_line_end   (i_line_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_char_out   (o_char_out),
        .o_field_class(o_field_class),
        .o_arg_index  (o_arg_index),
        .o_field_start(o_field_start),
        .o_column     (o_column),
        .o_label_error(o_label_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit ch_blank(logic [7:0] c);
        return c == alft_pkg::CH_SPACE || c == alft_pkg::CH_TAB;
    endfunction

    function automatic bit ch_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit ch_word_head(logic [7:0] c);
        return ch_letter(c) || c == alft_pkg::CH_UNDER || c == alft_pkg::CH_DOT;
    endfunction

    function automatic bit ch_word(logic [7:0] c);
        return ch_word_head(c) || (c >= "0" && c <= "9") || c == alft_pkg::CH_AT;
    endfunction

    function automatic void mark(alft_pkg::t_class c, logic s);
        tag_cls = c;
        tag_st = s;
    endfunction

    function automatic void open_comment();
        mark(alft_pkg::CLS_COMMENT, 1'b1);
        line_ph = alft_pkg::PH_COMMENT;
    endfunction

    function automatic void to_trail(logic [7:0] c);
        if (ch_blank(c)) begin
            mark(alft_pkg::CLS_SEP, 1'b0);
            line_ph = alft_pkg::PH_TRAIL;
        end else begin
            open_comment();
        end
    endfunction

    function automatic void end_arg(logic [7:0] c);
        mark(alft_pkg::CLS_SEP, 1'b0);
        if (c == alft_pkg::CH_COMMA) begin
            line_ph = alft_pkg::PH_ARG_SEEK;
        end else if (c == alft_pkg::CH_SEMI || ch_blank(c)) begin
            line_ph = alft_pkg::PH_TRAIL;
        end else begin
            line_ph = alft_pkg::PH_ARG_NEXT;
        end
    endfunction

    function automatic void new_arg(logic [7:0] c);
        if (n_args >= alft_pkg::MAX_ARGS) begin
            to_trail(c);
            return;
        end
        n_args++;
        if (c == alft_pkg::CH_DQ) begin
            mark(alft_pkg::CLS_ARG, 1'b1);
            line_ph = alft_pkg::PH_STRING;
        end else if (c == alft_pkg::CH_SQ) begin
            mark(alft_pkg::CLS_ARG, 1'b1);
            line_ph = alft_pkg::PH_CHAR1;
        end else if (c == alft_pkg::CH_COMMA || c == alft_pkg::CH_SEMI || ch_blank(c)) begin
            end_arg(c);
        end else begin
            mark(alft_pkg::CLS_ARG, 1'b1);
            line_ph = alft_pkg::PH_PLAIN;
        end
    endfunction

    function automatic void seek_arg(logic [7:0] c);
        if (ch_blank(c)) begin
            mark(alft_pkg::CLS_SEP, 1'b0);
            line_ph = alft_pkg::PH_ARG_SEEK;
        end else if (c == alft_pkg::CH_SEMI) begin
            open_comment();
        end else begin
            new_arg(c);
        end
    endfunction

    function automatic void seek_op(logic [7:0] c, bit has_nx, logic [7:0] nx);
        if (ch_blank(c)) begin
            mark(alft_pkg::CLS_SEP, 1'b0);
            line_ph = alft_pkg::PH_OP_SEEK;
        end else if (c == alft_pkg::CH_SEMI) begin
            open_comment();
        end else if (c == alft_pkg::CH_STAR && has_nx && nx == alft_pkg::CH_EQ) begin
            mark(alft_pkg::CLS_OPCODE, 1'b1);
            line_ph = alft_pkg::PH_STAR_EQ;
        end else if (c == alft_pkg::CH_EQ) begin
            mark(alft_pkg::CLS_OPCODE, 1'b1);
            line_ph = alft_pkg::PH_ARG_SEEK;
        end else if (ch_word_head(c)) begin
            mark(alft_pkg::CLS_OPCODE, 1'b1);
            line_ph = alft_pkg::PH_OPCODE;
        end else begin
            new_arg(c);
        end
    endfunction

    function automatic void tag_char(logic [7:0] c, bit has_nx, logic [7:0] nx);
        bit lab;
        bit spec;
        lab = ch_word(c) || (macro_on && c == alft_pkg::CH_BSL);
        spec = c == alft_pkg::CH_EQ || c == alft_pkg::CH_STAR;
        tag_err = 1'b0;
        case (line_ph)
            alft_pkg::PH_START: begin
                if (c == alft_pkg::CH_SEMI || c == alft_pkg::CH_STAR
                        || c == alft_pkg::CH_HASH) begin
                    open_comment();
                end else if (ch_blank(c)) begin
                    mark(alft_pkg::CLS_SEP, 1'b0);
                    line_ph = alft_pkg::PH_OP_SEEK;
                end else if (ch_word_head(c) || (macro_on && c == alft_pkg::CH_BSL)) begin
                    mark(alft_pkg::CLS_LABEL, 1'b1);
                    line_ph = alft_pkg::PH_LABEL;
                end else begin
                    tag_err = 1'b1;
                    seek_op(c, has_nx, nx);
                end
            end
            alft_pkg::PH_LABEL: begin
                if (lab) begin
                    mark(alft_pkg::CLS_LABEL, 1'b0);
                end else if (ch_blank(c)) begin
                    mark(alft_pkg::CLS_SEP, 1'b0);
                    line_ph = alft_pkg::PH_OP_SEEK;
                end else if (spec) begin
                    seek_op(c, has_nx, nx);
                end else begin
                    mark(alft_pkg::CLS_SUFFIX, 1'b1);
                    line_ph = alft_pkg::PH_SUFFIX;
                end
            end
            alft_pkg::PH_SUFFIX: begin
                if (ch_blank(c)) begin
                    mark(alft_pkg::CLS_SEP, 1'b0);
                    line_ph = alft_pkg::PH_OP_SEEK;
                end else if (ch_word(c) || spec) begin
                    seek_op(c, has_nx, nx);
                end else begin
                    mark(alft_pkg::CLS_SUFFIX, 1'b0);
                end
            end
            alft_pkg::PH_OP_SEEK: seek_op(c, has_nx, nx);
            alft_pkg::PH_STAR_EQ: begin
                mark(alft_pkg::CLS_OPCODE, 1'b0);
                line_ph = alft_pkg::PH_ARG_SEEK;
            end
            alft_pkg::PH_OPCODE: begin
                if (ch_word(c)) begin
                    mark(alft_pkg::CLS_OPCODE, 1'b0);
                end else begin
                    seek_arg(c);
                end
            end
            alft_pkg::PH_ARG_SEEK: seek_arg(c);
            alft_pkg::PH_STRING: begin
                mark(alft_pkg::CLS_ARG, 1'b0);
                if (c == alft_pkg::CH_DQ) begin
                    line_ph = alft_pkg::PH_AFTER_LIT;
                end
            end
            alft_pkg::PH_CHAR1: begin
                mark(alft_pkg::CLS_ARG, 1'b0);
                line_ph = alft_pkg::PH_CHAR2;
            end
            alft_pkg::PH_CHAR2: begin
                if (c == alft_pkg::CH_SQ) begin
                    mark(alft_pkg::CLS_ARG, 1'b0);
                    line_ph = alft_pkg::PH_AFTER_LIT;
                end else begin
                    end_arg(c);
                end
            end
            alft_pkg::PH_PLAIN: begin
                if (c == alft_pkg::CH_COMMA || c == alft_pkg::CH_SEMI || ch_blank(c)) begin
                    end_arg(c);
                end else begin
                    mark(alft_pkg::CLS_ARG, 1'b0);
                end
            end
            alft_pkg::PH_AFTER_LIT: end_arg(c);
            alft_pkg::PH_ARG_NEXT: new_arg(c);
            alft_pkg::PH_TRAIL: to_trail(c);
            default: begin
                mark(alft_pkg::CLS_COMMENT, 1'b0);
                line_ph = alft_pkg::PH_COMMENT;
            end
        endcase
    endfunction

    function automatic void tag_item(logic [7:0] ch, logic eol);
        alft_pkg::t_result r;
        if (held_ok) begin
            tag_char(held_ch, !eol, ch);
            r.char_out = held_ch;
            r.cls = tag_cls;
            r.arg_index = 5'd0;
            if (tag_cls == alft_pkg::CLS_ARG && n_args > 0) begin
                r.arg_index = 5'((n_args - 1) & 31);
            end
            r.start = tag_st;
            r.column = 8'(col);
            r.err = tag_err;
            tags_due.push_back(r);
            if (col < alft_pkg::MAX_COLUMN) begin
                col++;
            end
        end
        if (eol) begin
            line_ph = alft_pkg::PH_START;
            n_args = 0;
            col = 0;
            held_ok = 1'b0;
            held_ch = 8'h00;
        end else begin
            held_ch = ch;
            held_ok = 1'b1;
        end
    endfunction

    function automatic void cmp_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $error("%s: expected %0d, got %0d", fname, exp_v, got_v);
            end
        end
    endfunction

    // input side: accept and predict
    always @(posedge i_clk) begin
        in_fire = run_on && i_in_valid && !o_in_stall;
        if (in_fire) begin
            tag_item(i_char_in, i_line_end);
            total_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (!run_on) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (line_q.size() > 0) begin
                cur = line_q.pop_front();
                i_in_valid <= 1'b1;
                i_char_in <= cur.ch;
                i_line_end <= cur.eol;
                if ($urandom_range(0, 99) < in_idle_pct) begin
                    in_gap = $urandom_range(1, 11);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side: stall and check
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 99) < out_idle_pct) begin
                out_gap = $urandom_range(1, 11);
            end
        end
    end

    always @(posedge i_clk) begin
        if (run_on && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (tags_due.size() == 0) begin
                fails++;
                $error("result with no item pending: char_out %0d", o_char_out);
            end else begin
                want = tags_due.pop_front();
                cmp_field("char_out", want.char_out, o_char_out);
                cmp_field("field_class", 8'(want.cls), 8'(o_field_class));
                cmp_field("arg_index", 8'(want.arg_index), 8'(o_arg_index));
                cmp_field("field_start", 8'(want.start), 8'(o_field_start));
                cmp_field("column", want.column, o_column);
                cmp_field("label_error", 8'(want.err), 8'(o_label_error));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (run_on);
        while (quiet < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("asm_line_field_tagger_unit verification failed");
        $finish;
    end

    // stimulus helpers
    task automatic put(logic [7:0] c);
        line_q.push_back('{ch: c, eol: 1'b0});
        total_sent++;
    endtask

    task automatic eol();
        line_q.push_back('{ch: 8'($urandom_range(0, 255)), eol: 1'b1});
        total_sent++;
        n_lines++;
    endtask

    task automatic put_blanks();
        repeat ($urandom_range(1, 2)) begin
            put($urandom_range(0, 1) ? alft_pkg::CH_SPACE : alft_pkg::CH_TAB);
        end
    endtask

    task automatic put_text(int max_len);
        repeat ($urandom_range(0, max_len)) put(8'($urandom_range(32, 126)));
    endtask

    function automatic logic [7:0] word_head();
        case ($urandom_range(0, 3))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return alft_pkg::CH_UNDER;
            default: return alft_pkg::CH_DOT;
        endcase
    endfunction

    function automatic logic [7:0] word_tail();
        case ($urandom_range(0, 5))
            0: return 8'("a" + $urandom_range(0, 25));
            1: return 8'("A" + $urandom_range(0, 25));
            2: return 8'("0" + $urandom_range(0, 9));
            3: return alft_pkg::CH_UNDER;
            4: return alft_pkg::CH_DOT;
            default: return alft_pkg::CH_AT;
        endcase
    endfunction

    task automatic put_word(int max_len);
        put(word_head());
        repeat ($urandom_range(0, max_len - 1)) put(word_tail());
    endtask

    task automatic well_formed();
        int kind;
        int n;
        bit lit;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            case ($urandom_range(0, 2))
                0: put(alft_pkg::CH_SEMI);
                1: put(alft_pkg::CH_STAR);
                default: put(alft_pkg::CH_HASH);
            endcase
            put_text(8);
            eol();
            return;
        end
        if ($urandom_range(0, 1)) begin
            if (macro_on && $urandom_range(0, 2) == 0) begin
                put(alft_pkg::CH_BSL);
            end else begin
                put(word_head());
            end
            repeat ($urandom_range(0, 5)) begin
                put($urandom_range(0, 9) ? word_tail() : alft_pkg::CH_BSL);
            end
            case ($urandom_range(0, 3))
                1: put(":");
                2: begin
                    put(":");
                    put(":");
                end
                3: put(8'($urandom_range(128, 255)));
                default: ;
            endcase
        end
        put_blanks();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            eol();
            return;
        end
        if (kind < 14) begin
            put_word(6);
        end else if (kind < 16) begin
            put(alft_pkg::CH_STAR);
            put(alft_pkg::CH_EQ);
        end else if (kind < 18) begin
            put(alft_pkg::CH_EQ);
        end else begin
            put(alft_pkg::CH_STAR);
        end
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 4);
        if (n > 0) begin
            put_blanks();
        end
        for (int i = 0; i < n; i++) begin
            lit = 1'b0;
            case ($urandom_range(0, 5))
                0: begin
                    put(alft_pkg::CH_DQ);
                    put_text(4);
                    if ($urandom_range(0, 9) == 0) begin
                        eol();
                        return;
                    end
                    put(alft_pkg::CH_DQ);
                    lit = 1'b1;
                end
                1: begin
                    put(alft_pkg::CH_SQ);
                    put(8'($urandom_range(32, 126)));
                    if ($urandom_range(0, 1)) begin
                        put(alft_pkg::CH_SQ);
                        lit = 1'b1;
                    end
                end
                2: ;
                3: put(8'("0" + $urandom_range(0, 9)));
                default: put_word(4);
            endcase
            if (i < n - 1) begin
                if (lit && $urandom_range(0, 3) == 0) begin
                    put("+");
                end else begin
                    put(alft_pkg::CH_COMMA);
                    if ($urandom_range(0, 3) == 0) begin
                        put_blanks();
                    end
                end
            end
        end
        case ($urandom_range(0, 3))
            0: begin
                put_blanks();
                put(alft_pkg::CH_SEMI);
                put_text(6);
            end
            1: begin
                put_blanks();
                put(word_head());
                put_text(5);
            end
            default: ;
        endcase
        eol();
    endtask

    task automatic random_lines(int n);
        int stop;
        stop = total_sent + n;
        while (total_sent < stop) begin
            if ($urandom_range(0, 99) < 80) begin
                well_formed();
            end else begin
                repeat ($urandom_range(0, 20)) put(8'($urandom_range(0, 255)));
                eol();
            end
        end
    endtask

    task automatic wait_drained();
        while (total_taken != total_sent || tags_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        macro_on = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_on = 1'b1;
        in_idle_pct = 25;
        out_idle_pct = 25;

        write_mode(1'b0);
        eol();
        put(alft_pkg::CH_SPACE);
        put(alft_pkg::CH_STAR);
        eol();
        put("a");
        put(":");
        put(alft_pkg::CH_STAR);
        put(alft_pkg::CH_EQ);
        put("5");
        eol();
        put(8'h00);
        put(alft_pkg::CH_COMMA);
        put(alft_pkg::CH_COMMA);
        put(alft_pkg::CH_SQ);
        put("x");
        put(alft_pkg::CH_SEMI);
        eol();
        put(alft_pkg::CH_TAB);
        put(alft_pkg::CH_DQ);
        put("a");
        put(8'hFF);
        eol();
        wait_drained();

        write_mode(1'b1);
        random_lines(180);
        wait_drained();

        // hold the output while the sender keeps pushing
        write_mode(1'b0);
        in_idle_pct = 0;
        hold_req = 1'b1;
        random_lines(180);
        wait_drained();

        // argument overflow and column saturation on one long line
        write_mode(1'b1);
        in_idle_pct = 30;
        put(alft_pkg::CH_SPACE);
        put("l");
        put("d");
        put("a");
        put(alft_pkg::CH_SPACE);
        repeat (40) begin
            put("1");
            put(alft_pkg::CH_COMMA);
        end
        while (col + line_q.size() < 262 && line_q.size() < 262) put("x");
        eol();
        random_lines(40);
        wait_drained();

        write_mode(1'b0);
        in_idle_pct = 0;
        out_idle_pct = 0;
        random_lines(120);
        wait_drained();
        repeat (6) @(negedge i_clk);

        if (tags_due.size() != 0) begin
            fails++;
            $error("%0d tagged characters never came out", tags_due.size());
        end
        $display("checked %0d tagged characters from %0d lines (%0d items), macro mode off and on",
                 n_checked, n_lines, total_sent);
        $display("lines held comments, literals, empty and surplus arguments, bad label starts");
        if (fails == 0) begin
            $display("asm_line_field_tagger_unit verification clean");
        end else begin
            $display("asm_line_field_tagger_unit verification failed");
        end
        $finish;
    end

endmodule
